// ===== hw/rtl/gwc_pkg.sv =====
package gwc_pkg;

  // pixel and result field widths
  localparam int PIX_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int IMAGE_WIDTH_W = 11;
  localparam int KERNEL_SIZE_W = 3;
  localparam int KROW_W    = 40;
  localparam int NUM_KROWS = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_KERNEL_SIZE = 3'd1,
    REG_KROW_0      = 3'd2,
    REG_KROW_1      = 3'd3,
    REG_KROW_2      = 3'd4,
    REG_KROW_3      = 3'd5,
    REG_KROW_4      = 3'd6
  } cfg_reg_e;

  // register reset values
  localparam logic [IMAGE_WIDTH_W-1:0] IMAGE_WIDTH_RST = 11'd640;
  localparam logic [KERNEL_SIZE_W-1:0] KERNEL_SIZE_RST = 3'd3;

  // default parameter values
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_KERNEL_DEF = 5;
  localparam int COEF_BITS_DEF  = 8;

  // gray weights, 8-bit fixed point
  localparam int GRAY_SUM_W = 16;
  localparam logic [GRAY_SUM_W-1:0] GRAY_WT_BLUE  = 16'd18;
  localparam logic [GRAY_SUM_W-1:0] GRAY_WT_GREEN = 16'd183;
  localparam logic [GRAY_SUM_W-1:0] GRAY_WT_RED   = 16'd54;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             start_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] filtered;
    logic             clamped;
    logic             end_of_line;
  } pix_out_t;

  // per-pixel side info carried down the pipeline
  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic             end_of_line;
    logic             first_col;
  } pix_tag_t;

endpackage

// ===== hw/rtl/gray_window_convolution.sv =====
// Streaming gray conversion and N by N window filter. Raster BGR pixels enter one per
// transaction, line by line at image_width pixels per line; start_of_frame restarts the
// position. Each pixel becomes gray = (18*blue + 183*green + 54*red) >> 8 and yields one
// result: its gray value, the kernel sum over the window whose bottom-right corner is the
// pixel (positions above or left of the image count as zero), clamped to 0..255 with a
// clamped flag, and an end_of_line mark. One pixel is taken every clock while the pipeline
// has room; the five pipeline stages keep taking pixels while a finished result waits on
// the output, until each stage holds one. The rate is set by the line store: one RAM word
// per column holding the earlier lines, read when the pixel is taken and written back as
// it leaves the first stage. The line store needs no clearing pass after reset. The user
// must write configuration only while the block is idle; the block does not enforce it.
module gray_window_convolution #(
  parameter int MAX_WIDTH  = gwc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = gwc_pkg::MAX_KERNEL_DEF,
  parameter int COEF_BITS  = gwc_pkg::COEF_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  gwc_pkg::pix_in_t                 in_data_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output gwc_pkg::pix_out_t                out_data_o,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [gwc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gwc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gwc_pkg::*;

  // configuration registers
  logic [IMAGE_WIDTH_W-1:0]            image_width_q;
  logic [KERNEL_SIZE_W-1:0]            kernel_size_q;
  logic [NUM_KROWS-1:0][KROW_W-1:0]    kernel_rows_q;

  // front stage to window stages
  logic     fr_valid, fr_ready;
  pix_tag_t fr_tag;
  logic [MAX_KERNEL-1:0][PIX_W-1:0] fr_column;

  // window stages to accumulator
  logic     wn_valid, wn_ready;
  pix_tag_t wn_tag;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][COEF_BITS+PIX_W:0] wn_prod;

  // register decode, writes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= IMAGE_WIDTH_RST;
      kernel_size_q <= KERNEL_SIZE_RST;
      kernel_rows_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH: image_width_q    <= cfg_data_i[IMAGE_WIDTH_W-1:0];
        REG_KERNEL_SIZE: kernel_size_q    <= cfg_data_i[KERNEL_SIZE_W-1:0];
        REG_KROW_0:      kernel_rows_q[0] <= cfg_data_i[KROW_W-1:0];
        REG_KROW_1:      kernel_rows_q[1] <= cfg_data_i[KROW_W-1:0];
        REG_KROW_2:      kernel_rows_q[2] <= cfg_data_i[KROW_W-1:0];
        REG_KROW_3:      kernel_rows_q[3] <= cfg_data_i[KROW_W-1:0];
        REG_KROW_4:      kernel_rows_q[4] <= cfg_data_i[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: raster position, line store access, gray value, window column
  gwc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_image_width_i (image_width_q),
    .up_valid_i        (in_valid_i),
    .up_ready_o        (in_ready_o),
    .up_data_i         (in_data_i),
    .dn_valid_o        (fr_valid),
    .dn_ready_i        (fr_ready),
    .dn_tag_o          (fr_tag),
    .dn_column_o       (fr_column)
  );

  // stages 2 and 3: window shift register, coefficient products
  gwc_window #(
    .MAX_KERNEL (MAX_KERNEL),
    .COEF_BITS  (COEF_BITS)
  ) u_window (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_kernel_size_i (kernel_size_q),
    .cfg_kernel_rows_i (kernel_rows_q),
    .up_valid_i        (fr_valid),
    .up_ready_o        (fr_ready),
    .up_tag_i          (fr_tag),
    .up_column_i       (fr_column),
    .dn_valid_o        (wn_valid),
    .dn_ready_i        (wn_ready),
    .dn_tag_o          (wn_tag),
    .dn_prod_o         (wn_prod)
  );

  // stages 4 and 5: row sums, total with clamp into the output register
  gwc_accum #(
    .MAX_KERNEL (MAX_KERNEL),
    .COEF_BITS  (COEF_BITS)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (wn_valid),
    .up_ready_o (wn_ready),
    .up_tag_i   (wn_tag),
    .up_prod_i  (wn_prod),
    .dn_valid_o (out_valid_o),
    .dn_ready_i (out_ready_i),
    .dn_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/gwc_ram.sv =====
module gwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gwc_front.sv =====
module gwc_front #(
  parameter int MAX_WIDTH  = gwc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = gwc_pkg::MAX_KERNEL_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [gwc_pkg::IMAGE_WIDTH_W-1:0]     cfg_image_width_i,
  input  logic                                  up_valid_i,
  output logic                                  up_ready_o,
  input  gwc_pkg::pix_in_t                      up_data_i,
  output logic                                  dn_valid_o,
  input  logic                                  dn_ready_i,
  output gwc_pkg::pix_tag_t                     dn_tag_o,
  output logic [MAX_KERNEL-1:0][gwc_pkg::PIX_W-1:0] dn_column_o
);
  import gwc_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;
  localparam int ROWS_W = $clog2(MAX_KERNEL + 1);
  localparam int LINES  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int LINE_W = LINES * PIX_W;
  localparam logic [ROWS_W-1:0] ROWS_MAX = ROWS_W'(MAX_KERNEL - 1);

  logic [WID_W-1:0]  width;
  logic [COL_W-1:0]  col_q, col_d, col;
  logic [ROWS_W-1:0] rows_q, rows_d, rows;
  logic              eol;
  logic              in_fire, a_fire;

  logic              a_valid_q;
  pix_in_t           a_pix_q;
  logic [COL_W-1:0]  a_col_q;
  logic [ROWS_W-1:0] a_rows_q;
  logic              a_eol_q;
  logic              fwd_q;
  logic [LINE_W-1:0] fwd_line_q;

  logic [GRAY_SUM_W-1:0] gray_sum;
  logic [PIX_W-1:0]      gray;
  logic [LINE_W-1:0]     ram_rdata, line, wdata;

  // effective line width
  always_comb begin
    if (cfg_image_width_i == '0) begin
      width = WID_W'(1);
    end else if (32'(cfg_image_width_i) > MAX_WIDTH) begin
      width = WID_W'(MAX_WIDTH);
    end else begin
      width = WID_W'(cfg_image_width_i);
    end
  end

  // raster position of the incoming pixel and the one after it
  always_comb begin
    col  = col_q;
    rows = rows_q;
    if (up_data_i.start_of_frame) begin
      col  = '0;
      rows = '0;
    end else if ({1'b0, col_q} >= width) begin
      col  = '0;
      rows = (rows_q == ROWS_MAX) ? rows_q : rows_q + ROWS_W'(1);
    end
    eol = (WID_W'(col) + WID_W'(1)) >= width;
    if (eol) begin
      col_d  = '0;
      rows_d = (rows == ROWS_MAX) ? rows : rows + ROWS_W'(1);
    end else begin
      col_d  = col + COL_W'(1);
      rows_d = rows;
    end
  end

  assign up_ready_o = !a_valid_q || dn_ready_i;
  assign in_fire    = up_valid_i && up_ready_o;
  assign a_fire     = a_valid_q && dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      col_q     <= '0;
      rows_q    <= '0;
    end else begin
      if (up_ready_o) begin
        a_valid_q <= up_valid_i;
      end
      if (in_fire) begin
        col_q  <= col_d;
        rows_q <= rows_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_pix_q    <= up_data_i;
      a_col_q    <= col;
      a_rows_q   <= rows;
      a_eol_q    <= eol;
      // same column written as it is read: take the new word
      fwd_q      <= a_fire && (a_col_q == col);
      fwd_line_q <= wdata;
    end
  end

  gwc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (a_fire),
    .waddr_i (a_col_q),
    .wdata_i (wdata),
    .re_i    (in_fire),
    .raddr_i (col),
    .rdata_o (ram_rdata)
  );

  assign gray_sum = GRAY_WT_BLUE  * GRAY_SUM_W'(a_pix_q.blue)
                  + GRAY_WT_GREEN * GRAY_SUM_W'(a_pix_q.green)
                  + GRAY_WT_RED   * GRAY_SUM_W'(a_pix_q.red);
  assign gray = gray_sum[GRAY_SUM_W-1 -: PIX_W];
  assign line = fwd_q ? fwd_line_q : ram_rdata;

  // column of the window, masked above the image; line word shifts down
  always_comb begin
    dn_column_o    = '0;
    dn_column_o[0] = gray;
    for (int k = 1; k < MAX_KERNEL; k++) begin
      if (ROWS_W'(k) <= a_rows_q) begin
        dn_column_o[k] = line[(k-1)*PIX_W +: PIX_W];
      end
    end
    wdata              = line;
    wdata[PIX_W-1:0]   = gray;
    for (int k = 1; k < LINES; k++) begin
      wdata[k*PIX_W +: PIX_W] = line[(k-1)*PIX_W +: PIX_W];
    end
  end

  assign dn_valid_o = a_valid_q;
  assign dn_tag_o   = '{gray: gray, end_of_line: a_eol_q, first_col: (a_col_q == '0)};

endmodule

// ===== hw/rtl/gwc_window.sv =====
module gwc_window #(
  parameter int MAX_KERNEL = gwc_pkg::MAX_KERNEL_DEF,
  parameter int COEF_BITS  = gwc_pkg::COEF_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [gwc_pkg::KERNEL_SIZE_W-1:0]             cfg_kernel_size_i,
  input  logic [gwc_pkg::NUM_KROWS-1:0][gwc_pkg::KROW_W-1:0] cfg_kernel_rows_i,
  input  logic                                          up_valid_i,
  output logic                                          up_ready_o,
  input  gwc_pkg::pix_tag_t                             up_tag_i,
  input  logic [MAX_KERNEL-1:0][gwc_pkg::PIX_W-1:0]     up_column_i,
  output logic                                          dn_valid_o,
  input  logic                                          dn_ready_i,
  output gwc_pkg::pix_tag_t                             dn_tag_o,
  output logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][COEF_BITS+gwc_pkg::PIX_W:0] dn_prod_o
);
  import gwc_pkg::*;

  localparam int PROD_W = COEF_BITS + PIX_W + 1;
  localparam int N_W    = $clog2(MAX_KERNEL + 1);
  localparam int EXT_W  = (MAX_KERNEL * COEF_BITS > KROW_W) ? MAX_KERNEL * COEF_BITS : KROW_W;

  logic [N_W-1:0] n;
  logic [MAX_KERNEL-1:0][EXT_W-1:0] kern_ext;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][COEF_BITS-1:0] coef;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PROD_W-1:0]    prod;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0]     win_q, win_d;

  logic     b_valid_q, c_valid_q;
  logic     b_en, c_en;
  pix_tag_t b_tag_q, c_tag_q;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PROD_W-1:0] c_prod_q;

  assign c_en       = !c_valid_q || dn_ready_i;
  assign b_en       = !b_valid_q || c_en;
  assign up_ready_o = b_en;

  // window: row index is lines above, highest column is the newest pixel
  always_comb begin
    for (int a = 0; a < MAX_KERNEL; a++) begin
      for (int j = 0; j < MAX_KERNEL - 1; j++) begin
        win_d[a][j] = up_tag_i.first_col ? '0 : win_q[a][j+1];
      end
      win_d[a][MAX_KERNEL-1] = up_column_i[a];
    end
  end

  // effective kernel side
  always_comb begin
    if (cfg_kernel_size_i == '0) begin
      n = N_W'(1);
    end else if (32'(cfg_kernel_size_i) > MAX_KERNEL) begin
      n = N_W'(MAX_KERNEL);
    end else begin
      n = N_W'(cfg_kernel_size_i);
    end
  end

  // coefficient rows past the register set are zero
  always_comb begin
    for (int k = 0; k < MAX_KERNEL; k++) begin
      kern_ext[k] = (k < NUM_KROWS) ? EXT_W'(cfg_kernel_rows_i[k]) : '0;
    end
  end

  // map kernel (row, col) onto the bottom-right n by n corner of the window
  always_comb begin
    coef = '0;
    for (int nn = 1; nn <= MAX_KERNEL; nn++) begin
      if (n == N_W'(nn)) begin
        for (int a = 0; a < nn; a++) begin
          for (int j = MAX_KERNEL - nn; j < MAX_KERNEL; j++) begin
            coef[a][j] = kern_ext[nn-1-a][(j-MAX_KERNEL+nn)*COEF_BITS +: COEF_BITS];
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < MAX_KERNEL; a++) begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
        prod[a][j] = PROD_W'($signed(coef[a][j]) * $signed({1'b0, win_q[a][j]}));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      win_q     <= '0;
    end else begin
      if (b_en) begin
        b_valid_q <= up_valid_i;
        if (up_valid_i) begin
          win_q <= win_d;
        end
      end
      if (c_en) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en && up_valid_i) begin
      b_tag_q <= up_tag_i;
    end
    if (c_en && b_valid_q) begin
      c_tag_q  <= b_tag_q;
      c_prod_q <= prod;
    end
  end

  assign dn_valid_o = c_valid_q;
  assign dn_tag_o   = c_tag_q;
  assign dn_prod_o  = c_prod_q;

endmodule

// ===== hw/rtl/gwc_accum.sv =====
module gwc_accum #(
  parameter int MAX_KERNEL = gwc_pkg::MAX_KERNEL_DEF,
  parameter int COEF_BITS  = gwc_pkg::COEF_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          up_valid_i,
  output logic                                          up_ready_o,
  input  gwc_pkg::pix_tag_t                             up_tag_i,
  input  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][COEF_BITS+gwc_pkg::PIX_W:0] up_prod_i,
  output logic                                          dn_valid_o,
  input  logic                                          dn_ready_i,
  output gwc_pkg::pix_out_t                             dn_data_o
);
  import gwc_pkg::*;

  localparam int PROD_W = COEF_BITS + PIX_W + 1;
  localparam int ROW_W  = PROD_W + 3;
  localparam int SUM_W  = ROW_W + 3;

  logic signed [MAX_KERNEL-1:0][ROW_W-1:0] row_sum;
  logic signed [SUM_W-1:0] total;
  pix_out_t    result;

  logic     d_valid_q, o_valid_q;
  logic     d_en, o_en;
  pix_tag_t d_tag_q;
  logic [MAX_KERNEL-1:0][ROW_W-1:0] d_row_q;
  pix_out_t o_data_q;

  assign o_en       = !o_valid_q || dn_ready_i;
  assign d_en       = !d_valid_q || o_en;
  assign up_ready_o = d_en;

  always_comb begin
    for (int a = 0; a < MAX_KERNEL; a++) begin
      row_sum[a] = '0;
      for (int j = 0; j < MAX_KERNEL; j++) begin
        row_sum[a] = ROW_W'($signed(row_sum[a]) + ROW_W'($signed(up_prod_i[a][j])));
      end
    end
  end

  always_comb begin
    total = '0;
    for (int a = 0; a < MAX_KERNEL; a++) begin
      total = SUM_W'($signed(total) + SUM_W'($signed(d_row_q[a])));
    end
    result.gray        = d_tag_q.gray;
    result.end_of_line = d_tag_q.end_of_line;
    if (total < 0) begin
      result.filtered = '0;
      result.clamped  = 1'b1;
    end else if (total > $signed(SUM_W'(PIX_MAX))) begin
      result.filtered = PIX_MAX;
      result.clamped  = 1'b1;
    end else begin
      result.filtered = total[PIX_W-1:0];
      result.clamped  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (d_en) begin
        d_valid_q <= up_valid_i;
      end
      if (o_en) begin
        o_valid_q <= d_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_en && up_valid_i) begin
      d_tag_q <= up_tag_i;
      d_row_q <= row_sum;
    end
    if (o_en && d_valid_q) begin
      o_data_q <= result;
    end
  end

  assign dn_valid_o = o_valid_q;
  assign dn_data_o  = o_data_q;

endmodule

// ===== hw/rtl/gwc_checker.sv =====
module gwc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input gwc_pkg::pix_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gwc_pkg::pix_out_t out_data_o
);
  import gwc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // clamp flag only with a saturated value
  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clamped |->
      (out_data_o.filtered == '0) || (out_data_o.filtered == PIX_MAX))
    else $error("clamped result not at a limit");

  // pipeline never blocks input while the output side is free
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with output free");

  // no result during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result during reset");

endmodule

bind gray_window_convolution gwc_checker u_checker (.*);

// ===== bench/tb.sv =====
module tb;
  import gwc_pkg::*;

  localparam int MAX_W        = MAX_WIDTH_DEF;
  localparam int MAX_K        = MAX_KERNEL_DEF;
  localparam int COEF_W       = COEF_BITS_DEF;
  localparam int RESET_CYCLES = 12;
  // five pipeline stages, plus margin
  localparam int SETTLE_CYCLES = 10;
  localparam int RUN_LIMIT     = 2_000_000;
  localparam int RAND_PHASES   = 12;

  // dut inputs, known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b1;
  logic                 in_valid_i  = 1'b0;
  pix_in_t              in_data_i   = '0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  // dut outputs
  logic     in_ready_o;
  logic     out_valid_o;
  pix_out_t out_data_o;

  // idling of the two sides, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt   = 0;

  // shadow of the configuration registers
  logic [IMAGE_WIDTH_W-1:0] pred_width;
  logic [KERNEL_SIZE_W-1:0] pred_ksize;
  logic [KROW_W-1:0]        pred_krow [NUM_KROWS];

  // shadow of the pixel state: earlier lines, window, raster position
  logic [PIX_W-1:0] line_hist [MAX_K-1][MAX_W];
  logic [PIX_W-1:0] win_pix [MAX_K][MAX_K];
  int unsigned      col_pos;
  int unsigned      rows_avail;

  // filter results still owed by the dut, oldest first
  pix_out_t pending_q[$];

  gray_window_convolution uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // gray conversion and window filter for one pixel, advancing the shadow state
  function automatic pix_out_t predict_pixel(input pix_in_t px);
    int unsigned              w;
    int unsigned              n;
    int unsigned              col;
    int unsigned              gsum;
    logic [PIX_W-1:0]         gray_v;
    logic [PIX_W-1:0]         taps [MAX_K];
    logic signed [COEF_W-1:0] coef;
    longint                   acc;
    pix_out_t                 res;
    w = pred_width;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    n = pred_ksize;
    if (n == 0) n = 1;
    if (n > MAX_K) n = MAX_K;

    // frame restart, or a line cut short by a lowered width
    if (px.start_of_frame) begin
      col_pos    = 0;
      rows_avail = 0;
    end else if (col_pos >= w) begin
      col_pos = 0;
      if (rows_avail < MAX_K - 1) rows_avail++;
    end
    col = col_pos;

    gsum = GRAY_WT_BLUE * px.blue + GRAY_WT_GREEN * px.green + GRAY_WT_RED * px.red;
    gray_v = PIX_W'(gsum >> 8);

    // vertical column at this position, zero above the image
    taps[0] = gray_v;
    for (int k = 1; k < MAX_K; k++) begin
      taps[k] = (k <= rows_avail) ? line_hist[k-1][col] : '0;
    end
    for (int k = MAX_K - 1; k >= 2; k--) begin
      line_hist[k-1][col] = line_hist[k-2][col];
    end
    line_hist[0][col] = gray_v;

    // window restarts at the left edge
    if (col == 0) begin
      foreach (win_pix[k, l]) win_pix[k][l] = '0;
    end
    for (int k = 0; k < MAX_K; k++) begin
      for (int l = 0; l < MAX_K - 1; l++) win_pix[k][l] = win_pix[k][l+1];
      win_pix[k][MAX_K-1] = taps[k];
    end

    // kernel row 0 is the top line of the window, column 0 the leftmost
    acc = 0;
    for (int k = 0; k < n; k++) begin
      for (int l = 0; l < n; l++) begin
        coef = pred_krow[k][l*COEF_W +: COEF_W];
        acc += longint'(coef) * longint'(win_pix[n-1-k][MAX_K-n+l]);
      end
    end

    if (acc < 0) begin
      res.filtered = '0;
      res.clamped  = 1'b1;
    end else if (acc > longint'(PIX_MAX)) begin
      res.filtered = PIX_MAX;
      res.clamped  = 1'b1;
    end else begin
      res.filtered = PIX_W'(acc);
      res.clamped  = 1'b0;
    end
    res.gray        = gray_v;
    res.end_of_line = (col + 1 >= w);

    if (res.end_of_line) begin
      col_pos = 0;
      if (rows_avail < MAX_K - 1) rows_avail++;
    end else begin
      col_pos = col + 1;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                             input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // compare every result transaction with the oldest owed result
  always @(posedge clk_i) begin : score_results
    pix_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result with no pixel pending: gray %0d filtered %0d",
               out_data_o.gray, out_data_o.filtered);
        mismatch_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("gray", want.gray, out_data_o.gray);
        check_field("filtered", want.filtered, out_data_o.filtered);
        check_field("clamped", PIX_W'(want.clamped), PIX_W'(out_data_o.clamped));
        check_field("end_of_line", PIX_W'(want.end_of_line),
                    PIX_W'(out_data_o.end_of_line));
      end
    end
  end

  // one pixel transaction; valid stays up until taken
  task automatic send_pixel(input pix_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(predict_pixel(px));
  endtask

  // stop sending and let every owed result come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH: pred_width = val[IMAGE_WIDTH_W-1:0];
      REG_KERNEL_SIZE: pred_ksize = val[KERNEL_SIZE_W-1:0];
      default:         pred_krow[idx - REG_KROW_0] = val[KROW_W-1:0];
    endcase
  endtask

  // full register set; unused upper data bits carry junk
  task automatic configure(input int unsigned width_val, input int unsigned ksize_val,
                           input logic [NUM_KROWS-1:0][KROW_W-1:0] rows);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    data = CFG_DATA_W'({$urandom, $urandom});
    data[IMAGE_WIDTH_W-1:0] = IMAGE_WIDTH_W'(width_val);
    write_reg(REG_IMAGE_WIDTH, data);
    data = CFG_DATA_W'({$urandom, $urandom});
    data[KERNEL_SIZE_W-1:0] = KERNEL_SIZE_W'(ksize_val);
    write_reg(REG_KERNEL_SIZE, data);
    for (int i = 0; i < NUM_KROWS; i++) begin
      write_reg(cfg_reg_e'(REG_KROW_0 + i), rows[i]);
    end
  endtask

  function automatic pix_in_t rand_pixel(input logic sof, input int unsigned top);
    pix_in_t px;
    px.blue           = PIX_W'($urandom_range(top));
    px.green          = PIX_W'($urandom_range(top));
    px.red            = PIX_W'($urandom_range(top));
    px.start_of_frame = sof;
    return px;
  endfunction

  // reset values: zero kernel, so every sum is zero
  task automatic test_reset_defaults();
    send_pixel('{PIX_MAX, PIX_MAX, PIX_MAX, 1'b1});
    send_pixel('{8'd0, 8'd0, 8'd0, 1'b0});
    send_pixel('{PIX_MAX, 8'd0, 8'd0, 1'b0});
    send_pixel('{8'd0, 8'd0, PIX_MAX, 1'b0});
  endtask

  // single tap at the largest and the most negative coefficient
  task automatic test_clamp_limits();
    logic [NUM_KROWS-1:0][KROW_W-1:0] rows;
    rows    = '0;
    rows[0] = KROW_W'(8'h7F);
    configure(4, 1, rows);
    send_pixel('{PIX_MAX, PIX_MAX, PIX_MAX, 1'b1});
    send_pixel('{8'd0, 8'd0, 8'd0, 1'b0});
    rows[0] = KROW_W'(8'h80);
    configure(4, 1, rows);
    send_pixel('{PIX_MAX, PIX_MAX, PIX_MAX, 1'b1});
    send_pixel('{8'd0, 8'd0, 8'd0, 1'b0});
  endtask

  // oversized kernel over a tiny image: most of the window lies outside
  task automatic test_window_edges();
    logic [NUM_KROWS-1:0][KROW_W-1:0] rows;
    for (int i = 0; i < NUM_KROWS; i++) rows[i] = 40'h01_0101_0101;
    configure(3, 7, rows);
    for (int i = 0; i < 9; i++) send_pixel(rand_pixel(i == 0, 40));
  endtask

  // width zero acts as one, kernel size zero acts as one
  task automatic test_width_zero();
    logic [NUM_KROWS-1:0][KROW_W-1:0] rows;
    rows    = '0;
    rows[0] = KROW_W'(8'h01);
    configure(0, 0, rows);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(i == 0, 255));
  endtask

  // width lowered below the current column: next pixel opens a new line
  task automatic test_width_lowered();
    logic [NUM_KROWS-1:0][KROW_W-1:0] rows;
    rows    = '0;
    rows[0] = KROW_W'(16'h0101);
    rows[1] = KROW_W'(16'h01FF);
    configure(4, 2, rows);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(i == 0, 255));
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(1'b0, 255));
  endtask

  // phases of random frames under changing settings and idling
  task automatic test_random_frames();
    logic [NUM_KROWS-1:0][KROW_W-1:0] rows;
    int unsigned width_v;
    int unsigned ksize_v;
    int unsigned count;
    int unsigned left;
    int unsigned frame_len;
    logic        sof;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase

      // one long frame at the widest raster, then small rasters
      if (ph == 0) begin
        width_v = 2047;
        ksize_v = MAX_K;
        count   = 1100;
      end else begin
        width_v = (ph == 1) ? 1 : $urandom_range(12, 2);
        ksize_v = ph % 8;
        count   = 45;
      end

      // full-range, small signed, or a single unit tap
      case (ph % 3)
        0: for (int r = 0; r < NUM_KROWS; r++) rows[r] = KROW_W'({$urandom, $urandom});
        1: begin
          for (int r = 0; r < NUM_KROWS; r++) begin
            for (int c = 0; c < MAX_K; c++) begin
              rows[r][c*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(4)) - 2);
            end
          end
        end
        default: begin
          rows = '0;
          rows[$urandom_range(NUM_KROWS-1)][$urandom_range(MAX_K-1)*COEF_W +: COEF_W] =
            COEF_W'(1);
        end
      endcase
      configure(width_v, ksize_v, rows);

      // well-formed frames, with a few stray frame restarts
      left = 0;
      for (int i = 0; i < count; i++) begin
        if (left == 0) begin
          sof       = 1'b1;
          frame_len = (ph == 0) ? count : width_v * $urandom_range(7, 2);
          left      = frame_len;
        end else begin
          sof = ($urandom_range(99) < 3);
        end
        left--;
        send_pixel(rand_pixel(sof, 255));
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    pred_width = IMAGE_WIDTH_RST;
    pred_ksize = KERNEL_SIZE_RST;
    foreach (pred_krow[i]) pred_krow[i] = '0;
    foreach (line_hist[k, c]) line_hist[k][c] = '0;
    foreach (win_pix[k, l]) win_pix[k][l] = '0;
    col_pos    = 0;
    rows_avail = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_clamp_limits();
    test_window_edges();
    test_width_zero();
    test_width_lowered();
    test_random_frames();
    wait_idle();

    if (mismatch_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #RUN_LIMIT;
    $display("Mismatches found");
    $finish;
  end

endmodule
